// ----- src/crs_pkg.sv -----
// ----------------------------------------------------------------------------
// crs_pkg: GF(256) helpers for the Cauchy RS parity encoder
// Field arithmetic over x^8+x^4+x^3+x^2+1, the elaboration-time inverse
// table, and the register index codes.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int unsigned MAX_PARITY = 16;
  localparam int unsigned ROW_W      = $clog2(MAX_PARITY);

  localparam logic [8:0] GF_POLY = 9'h11D;

  // register index codes (decoded from paddr[2])
  localparam logic REG_DATA_SHARDS   = 1'b0;
  localparam logic REG_PARITY_SHARDS = 1'b1;

  typedef logic [255:0][7:0] inv_tbl_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] y;
    logic [7:0] r;
    x = {1'b0, a};
    y = b;
    r = '0;
    for (int n = 0; n < 8; n++) begin
      if (y[0]) r = r ^ x[7:0];
      y = y >> 1;
      x = x << 1;
      if (x[8]) x = x ^ GF_POLY;
    end
    return r;
  endfunction

  // a^254; zero maps to zero
  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] base;
    logic [7:0] e;
    r    = 8'd1;
    base = a;
    e    = 8'd254;
    for (int n = 0; n < 8; n++) begin
      if (e[0]) r = gf_mul(r, base);
      base = gf_mul(base, base);
      e    = e >> 1;
    end
    return r;
  endfunction

  function automatic inv_tbl_t gf_inv_table();
    inv_tbl_t t;
    for (int a = 0; a < 256; a++) begin
      t[a] = gf_inv(8'(a));
    end
    return t;
  endfunction

  localparam inv_tbl_t GF_INV = gf_inv_table();

endpackage

// ----- src/cauchy_rs_parity_encoder.sv -----
// ----------------------------------------------------------------------------
// cauchy_rs_parity_encoder: systematic Cauchy Reed-Solomon parity encoder
// Takes data bytes column by column, accumulates m parity bytes over
// GF(256) and streams them out after the k-th byte of each column.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+--------------------------
//  data     | in        | data_valid_i / data_ready_o   | data_byte_i
//  parity   | out       | parity_valid_o / parity_ready_i | parity_byte_o, parity_row_o,
//           |           |                               | last_of_run_o
//  config   | in        | APB psel/penable/pwrite       | paddr, pwdata, prdata
//
// One data byte per cycle unless a closing byte waits for the parity buffer: a
// byte is held in the input register, then all parity rows are updated at once
// by the table lookup and GF multiply. A finished column is copied into a shift
// buffer and leaves one parity byte per cycle while parity_ready_i is high; the
// next column finishes only once that buffer drains.
// Reset clears the accumulators, counter and valid flags; k and m reset to 1.
// ----------------------------------------------------------------------------
module cauchy_rs_parity_encoder
  import crs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       data_valid_i,
  output logic       data_ready_o,
  input  logic [7:0] data_byte_i,

  output logic       parity_valid_o,
  input  logic       parity_ready_i,
  output logic [7:0] parity_byte_o,
  output logic [3:0] parity_row_o,
  output logic       last_of_run_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] data_shards_q;
  logic [4:0] parity_shards_q;

  logic       stg_v_q;
  logic [7:0] stg_d_q;
  logic [7:0] cnt_q;

  logic [7:0] acc_q  [MAX_PARITY];
  logic [7:0] obuf_q [MAX_PARITY];
  logic [7:0] col_sum [MAX_PARITY];

  logic             obusy_q;
  logic [ROW_W-1:0] orow_q;
  logic [4:0]       om_q;

  logic [7:0] k_eff;
  logic [4:0] m_eff;
  logic [7:0] ypt;
  logic [7:0] cnt_inc;
  logic       col_done;
  logic       out_take;
  logic       out_last;
  logic       fire;
  logic       load;
  logic       cfg_wr;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_shards_q   <= 8'd1;
      parity_shards_q <= 5'd1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DATA_SHARDS:   data_shards_q   <= pwdata[7:0];
        REG_PARITY_SHARDS: parity_shards_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DATA_SHARDS:   prdata = {24'd0, data_shards_q};
      REG_PARITY_SHARDS: prdata = {27'd0, parity_shards_q};
      default:           prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ datapath
  assign k_eff = (data_shards_q == 8'd0) ? 8'd1 : data_shards_q;

  always_comb begin
    if (parity_shards_q == 5'd0)                    m_eff = 5'd1;
    else if (parity_shards_q > 5'(MAX_PARITY))      m_eff = 5'(MAX_PARITY);
    else                                            m_eff = parity_shards_q;
  end

  // Cauchy point of this data byte, formed modulo 256
  assign ypt     = {3'd0, m_eff} + cnt_q;
  assign cnt_inc = cnt_q + 8'd1;
  assign col_done = !((cnt_inc < k_eff) && (cnt_inc != 8'd0));

  always_comb begin
    for (int i = 0; i < MAX_PARITY; i++) begin
      if (5'(i) < m_eff) begin
        col_sum[i] = acc_q[i] ^ gf_mul(GF_INV[8'(i) ^ ypt], stg_d_q);
      end else begin
        col_sum[i] = acc_q[i];
      end
    end
  end

  assign out_take = obusy_q & parity_ready_i;
  assign out_last = ((5'(orow_q) + 5'd1) == om_q);

  // a finishing byte waits until the parity buffer is free or frees now
  assign fire = stg_v_q & (!col_done | !obusy_q | (out_take & out_last));
  assign load = fire & col_done;

  assign data_ready_o = !stg_v_q | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else if (data_ready_o) begin
      stg_v_q <= data_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_valid_i && data_ready_o) begin
      stg_d_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < MAX_PARITY; i++) acc_q[i] <= '0;
    end else if (fire) begin
      cnt_q <= col_done ? 8'd0 : cnt_inc;
      for (int i = 0; i < MAX_PARITY; i++) begin
        acc_q[i] <= col_done ? 8'd0 : col_sum[i];
      end
    end
  end

  // ------------------------------------------------------- parity buffer
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < MAX_PARITY; i++) obuf_q[i] <= col_sum[i];
    end else if (out_take) begin
      // advance: the current row always sits at the head
      for (int i = 0; i < MAX_PARITY - 1; i++) obuf_q[i] <= obuf_q[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obusy_q <= 1'b0;
      orow_q  <= '0;
      om_q    <= 5'd1;
    end else if (load) begin
      obusy_q <= 1'b1;
      orow_q  <= '0;
      om_q    <= m_eff;
    end else if (out_take) begin
      if (out_last) obusy_q <= 1'b0;
      orow_q <= orow_q + ROW_W'(1);
    end
  end

  assign parity_valid_o = obusy_q;
  assign parity_byte_o  = obuf_q[0];
  assign parity_row_o   = 4'(orow_q);
  assign last_of_run_o  = out_last;

  // ------------------------------------------------------------ checks
  a_row_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    obusy_q |-> ({1'b0, orow_q} < om_q))
    else $error("parity row beyond column size");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!obusy_q || (out_take && out_last)))
    else $error("column finished over an undrained parity buffer");

  a_load_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (parity_valid_o && (orow_q == '0) && (cnt_q == 8'd0)))
    else $error("finished column did not start a parity burst");

endmodule

// ----- tb/cauchy_rs_parity_encoder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cauchy_rs_parity_encoder_tb: self-checking bench for the Cauchy RS encoder
// Streams data bytes over the valid/ready request channel, keeps a GF(256)
// log/antilog model of the parity accumulators, and compares every parity
// byte with the oldest predicted one. A directed table comes first; random
// columns follow under several idle/stall mixes and a long receiver hold-off.
// ----------------------------------------------------------------------------
module cauchy_rs_parity_encoder_tb;
  import crs_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int SEND_IDLE[4]  = '{0, 62, 0, 28};
  localparam int RECV_STALL[4] = '{0, 0, 62, 28};

  typedef struct packed {
    logic [7:0] pbyte;
    logic [3:0] row;
    logic       last;
  } parity_t;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        sel;
    logic [31:0] value;
    logic        has_exp;
    logic [7:0]  exp_byte;
  } dir_row_t;

  localparam int N_DIRECTED = 24;
  localparam dir_row_t DIRECTED[N_DIRECTED] = '{
    // after reset k = m = 1: the coefficient is 1, parity equals the byte
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_0000, 1'b1, 8'h00},
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_00FF, 1'b1, 8'hFF},
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_0001, 1'b1, 8'h01},
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_0080, 1'b1, 8'h80},
    // zero shard counts act as one
    '{ROW_REG,  REG_DATA_SHARDS,   32'h0000_0000, 1'b0, 8'h00},
    '{ROW_REG,  REG_PARITY_SHARDS, 32'h0000_0000, 1'b0, 8'h00},
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_005A, 1'b1, 8'h5A},
    // upper write bits are dropped
    '{ROW_REG,  REG_PARITY_SHARDS, 32'hFFFF_FF04, 1'b0, 8'h00},
    '{ROW_REG,  REG_DATA_SHARDS,   32'h0000_0103, 1'b0, 8'h00},
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_00FF, 1'b0, 8'h00},
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_0000, 1'b0, 8'h00},
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_003C, 1'b0, 8'h00},
    // 31 parity rows saturate to the maximum
    '{ROW_REG,  REG_PARITY_SHARDS, 32'h0000_001F, 1'b0, 8'h00},
    '{ROW_REG,  REG_DATA_SHARDS,   32'h0000_0002, 1'b0, 8'h00},
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_00A5, 1'b0, 8'h00},
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_005A, 1'b0, 8'h00},
    // set k at a column start, then change m in the middle of the column
    '{ROW_REG,  REG_DATA_SHARDS,   32'h0000_0005, 1'b0, 8'h00},
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_0012, 1'b0, 8'h00},
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_0034, 1'b0, 8'h00},
    '{ROW_REG,  REG_PARITY_SHARDS, 32'h0000_0003, 1'b0, 8'h00},
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_0056, 1'b0, 8'h00},
    // counter already past the new k: the next byte closes the column
    '{ROW_REG,  REG_DATA_SHARDS,   32'h0000_0002, 1'b0, 8'h00},
    '{ROW_BYTE, REG_DATA_SHARDS,   32'h0000_0078, 1'b0, 8'h00},
    '{ROW_REG,  REG_PARITY_SHARDS, 32'h0000_0010, 1'b0, 8'h00}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        data_valid_i;
  logic        data_ready_o;
  logic [7:0]  data_byte_i;
  logic        parity_valid_o;
  logic        parity_ready_i;
  logic [7:0]  parity_byte_o;
  logic [3:0]  parity_row_o;
  logic        last_of_run_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // encoder model state
  logic [7:0]  gf_exp [0:511];
  int          gf_log [0:255];
  logic [7:0]  cfg_k;
  logic [4:0]  cfg_m;
  logic [7:0]  parity_acc [MAX_PARITY];
  logic [7:0]  col_count;
  parity_t     pending_parity[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_tickets;
  int err_count;
  int bytes_sent;
  int columns_done;
  int parity_seen;
  int reg_writes;

  cauchy_rs_parity_encoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_valid_i   (data_valid_i),
    .data_ready_o   (data_ready_o),
    .data_byte_i    (data_byte_i),
    .parity_valid_o (parity_valid_o),
    .parity_ready_i (parity_ready_i),
    .parity_byte_o  (parity_byte_o),
    .parity_row_o   (parity_row_o),
    .last_of_run_o  (last_of_run_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    if (a == 8'd0 || b == 8'd0) return 8'd0;
    return gf_exp[gf_log[a] + gf_log[b]];
  endfunction

  function automatic logic [7:0] gf_recip(input logic [7:0] a);
    if (a == 8'd0) return 8'd0;
    return gf_exp[255 - gf_log[a]];
  endfunction

  // Fold one data byte into every active parity row; close the column on the k-th byte.
  function automatic void accumulate_byte(input logic [7:0] d);
    int unsigned k_eff;
    int unsigned m_eff;
    logic [7:0]  ypt;
    k_eff = (cfg_k == 8'd0) ? 1 : cfg_k;
    m_eff = (cfg_m == 5'd0) ? 1 : ((cfg_m > MAX_PARITY) ? MAX_PARITY : cfg_m);
    ypt   = 8'(m_eff + col_count);
    for (int i = 0; i < m_eff; i++) begin
      parity_acc[i] ^= gf_times(gf_recip(8'(i) ^ ypt), d);
    end
    col_count++;
    if (col_count >= k_eff || col_count == 8'd0) begin
      for (int i = 0; i < m_eff; i++) begin
        pending_parity.insert(pending_parity.size(),
                              parity_t'{pbyte: parity_acc[i], row: 4'(i),
                                        last: (i == m_eff - 1)});
      end
      foreach (parity_acc[i]) parity_acc[i] = 8'd0;
      col_count = 8'd0;
      columns_done++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_byte(input logic [7:0] d, input logic has_exp = 1'b0,
                           input logic [7:0] exp_byte = 8'd0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      data_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    data_valid_i <= 1'b1;
    data_byte_i  <= d;
    do @(posedge clk_i); while (!data_ready_o);
    accumulate_byte(d);
    if (has_exp) begin
      pending_parity[pending_parity.size() - 1] =
        parity_t'{pbyte: exp_byte, row: 4'd0, last: 1'b1};
    end
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid, drain all parity, then let the pipeline settle.
  task automatic quiesce();
    data_valid_i <= 1'b0;
    while (pending_parity.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == REG_DATA_SHARDS) cfg_k = value[7:0];
    else cfg_m = value[4:0];
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // leave the bus idle before returning so back-to-back writes never retoggle psel in one step
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : parity_check
    parity_t want;
    if (rst_ni && parity_valid_o && parity_ready_i) begin
      parity_seen++;
      if (pending_parity.size() == 0) begin
        $error("parity byte %02h row %0d with nothing expected", parity_byte_o, parity_row_o);
        err_count++;
      end else begin
        want = pending_parity.pop_front();
        if (parity_byte_o !== want.pbyte) begin
          $error("parity_byte: expected %02h, got %02h", want.pbyte, parity_byte_o);
          err_count++;
        end
        if (parity_row_o !== want.row) begin
          $error("parity_row: expected %0d, got %0d", want.row, parity_row_o);
          err_count++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, last_of_run_o);
          err_count++;
        end
      end
    end
  end

  initial begin : parity_sink
    int hold_served;
    int hold_left;
    hold_served    = 0;
    hold_left      = 0;
    parity_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_tickets) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        parity_ready_i <= 1'b0;
      end else begin
        parity_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((data_valid_i && data_ready_o) || (parity_valid_o && parity_ready_i) ||
          (psel && penable && pready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("watchdog: no request moved in %0d cycles", STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [8:0]  x9;
    logic [7:0]  k_pick;
    logic [4:0]  m_pick;
    int          sent;
    int          n;
    err_count      = 0;
    bytes_sent     = 0;
    columns_done   = 0;
    parity_seen    = 0;
    reg_writes     = 0;
    hold_tickets   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    data_valid_i   = 1'b0;
    data_byte_i    = 8'd0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cfg_k          = 8'd1;
    cfg_m          = 5'd1;
    col_count      = 8'd0;
    foreach (parity_acc[i]) parity_acc[i] = 8'd0;

    // antilog table doubled so a sum of two logs needs no modulo
    x9 = 9'd1;
    gf_log[0] = 0;
    for (int i = 0; i < 255; i++) begin
      gf_exp[i]       = x9[7:0];
      gf_exp[i + 255] = x9[7:0];
      gf_log[x9[7:0]] = i;
      x9 = {x9[7:0], 1'b0};
      if (x9[8]) x9 ^= GF_POLY;
    end
    gf_exp[510] = gf_exp[0];
    gf_exp[511] = gf_exp[1];

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_REG) begin
        quiesce();
        write_reg(DIRECTED[r].sel, DIRECTED[r].value);
      end else begin
        send_byte(DIRECTED[r].value[7:0], DIRECTED[r].has_exp, DIRECTED[r].exp_byte);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      sent = 0;
      while (sent < 40) begin
        quiesce();
        case ($urandom_range(0, 9))
          0:       k_pick = 8'd0;
          1:       k_pick = 8'($urandom_range(9, 48));
          default: k_pick = 8'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 9))
          0:       m_pick = 5'd0;
          1:       m_pick = 5'($urandom_range(17, 31));
          default: m_pick = 5'($urandom_range(1, 16));
        endcase
        // now and then touch one register only, leaving the open column alive
        if ($urandom_range(0, 3) != 0 || ($urandom_range(0, 1) == 0)) begin
          write_reg(REG_DATA_SHARDS, ($urandom() & 32'hFFFF_FF00) | 32'(k_pick));
        end
        if ($urandom_range(0, 4) != 0) begin
          write_reg(REG_PARITY_SHARDS, ($urandom() & 32'hFFFF_FFE0) | 32'(m_pick));
        end
        n = $urandom_range(1, 24);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
        sent += n;
      end
    end

    // receiver holds off while short columns with full parity keep coming
    quiesce();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_DATA_SHARDS, 32'd2);
    write_reg(REG_PARITY_SHARDS, 32'(MAX_PARITY));
    hold_tickets++;
    repeat (30) send_byte(8'($urandom_range(0, 255)));

    data_valid_i <= 1'b0;
    while (pending_parity.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d data bytes, %0d columns, %0d parity bytes, %0d register writes",
             bytes_sent, columns_done, parity_seen, reg_writes);
    $display("including zero and saturated counts, mid-column updates and a long output stall");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- cauchy_rs_parity_encoder.f -----
src/crs_pkg.sv
src/cauchy_rs_parity_encoder.sv
tb/cauchy_rs_parity_encoder_tb.sv
